FILE: rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray/triangle intersector
// Widths of the edge, cross product and triple product stages follow from the coordinate width.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int CW    = 21;          // bits of one signed Q10.10 coordinate
	localparam int PKW   = 63;          // bits of one packed three-coordinate field
	localparam int EW    = CW + 1;      // edge, negated direction, offset
	localparam int PW    = 2 * EW;      // product of a pair of edge components
	localparam int XW    = PW + 1;      // cross product component
	localparam int XL    = XW / 2 + 1;  // low unsigned slice of a cross component
	localparam int XH    = XW - XL;     // high signed slice of a cross component
	localparam int DW    = EW + XW;     // one term of a triple product
	localparam int SW    = DW + 2;      // sum of three terms
	localparam int LW    = 20;          // ray limit and ray parameter
	localparam int TAGW  = 16;
	localparam int TQW   = 20;          // quotient bits of t
	localparam int UQW   = 17;          // quotient bits of u and v
	localparam int TFRAC = 10;
	localparam int DSH   = TQW - 1 - TFRAC;
	localparam int TRW   = SW + DSH + 1; // partial remainder of t
	localparam int URW   = SW + 1;       // partial remainder of u and v
	localparam int PRW   = TQW + 1 + CW; // t times a direction component
	localparam int SUMW  = PRW + 1;      // origin plus scaled direction

	typedef logic signed [EW-1:0] evec_t [3];

	typedef struct packed {
		logic [PKW-1:0]  org;
		logic [PKW-1:0]  dir;
		logic [LW-1:0]   lim;
		logic [TAGW-1:0] tri_tag;
		logic [TAGW-1:0] smp_tag;
		logic            hit;
	} side_t;

	typedef struct packed {
		logic [TRW-1:0] rt;
		logic [URW-1:0] ru;
		logic [URW-1:0] rv;
		logic [SW-1:0]  den;
		logic [TQW-1:0] qt;
		logic [UQW-1:0] qu;
		logic [UQW-1:0] qv;
	} div_t;

	function automatic logic signed [CW-1:0] coord(input logic [PKW-1:0] p, input int ax);
		return p[ax*CW +: CW];
	endfunction

endpackage

FILE: rtl/rti_div_pipe.sv
// ----------------------------------------------------------------------------
// rti_div_pipe: restoring divider pipeline, one quotient bit per stage
// Produces t, u and v quotients together; each stage has its own valid bit.
// ----------------------------------------------------------------------------
module rti_div_pipe import rti_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  div_t  in_data,
	input  side_t in_side,
	output logic  out_valid,
	input  logic  out_ready,
	output div_t  out_data,
	output side_t out_side
);

	div_t         st [TQW+1];
	side_t        sd [TQW+1];
	logic [TQW:0] vl;
	logic [TQW+1:1] rd;

	assign st[0] = in_data;
	assign sd[0] = in_side;
	assign vl[0] = in_valid;
	assign rd[TQW+1] = out_ready;
	assign in_ready  = rd[1];

	for (genvar g = 1; g <= TQW; g++) begin : g_stage
		logic [TRW-1:0] d9;
		logic [TRW-1:0] tdif;
		logic [URW-1:0] dn;
		logic [URW-1:0] udif;
		logic [URW-1:0] vdif;
		logic           tb;
		logic           ub;
		logic           vb;
		div_t           nx;

		assign rd[g] = !vl[g] || rd[g+1];

		always_comb begin
			nx   = st[g-1];
			d9   = TRW'(st[g-1].den) << DSH;
			dn   = URW'(st[g-1].den);
			tdif = st[g-1].rt - d9;
			udif = st[g-1].ru - dn;
			vdif = st[g-1].rv - dn;
			tb   = st[g-1].rt >= d9;
			ub   = st[g-1].ru >= dn;
			vb   = st[g-1].rv >= dn;
			nx.rt = (tb ? tdif : st[g-1].rt) << 1;
			nx.qt = {st[g-1].qt[TQW-2:0], tb};
			if (g <= UQW) begin
				nx.ru = (ub ? udif : st[g-1].ru) << 1;
				nx.rv = (vb ? vdif : st[g-1].rv) << 1;
				nx.qu = {st[g-1].qu[UQW-2:0], ub};
				nx.qv = {st[g-1].qv[UQW-2:0], vb};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl[g] <= 1'b0;
			end else if (rd[g]) begin
				vl[g] <= vl[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rd[g]) begin
				st[g] <= nx;
				sd[g] <= sd[g-1];
			end
		end
	end

	assign out_valid = vl[TQW];
	assign out_data  = st[TQW];
	assign out_side  = sd[TQW];

endmodule

FILE: rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect: pipelined ray/triangle hit test
// Solves the barycentric system by Cramer's rule and reports u, v, t and the
// hit point for every ray/triangle pair that hits.
// ----------------------------------------------------------------------------
// Usage: each input word on s_axis carries one ray (origin, direction, limit)
// and one triangle (three vertices) plus two tags. Each output word on m_axis
// carries one result; m_axis_tuser is the hit flag. Every input word yields
// exactly one output word, in order.
// On its way from acceptance to m_axis_tvalid each word passes these stages:
// 8 stages form edges, cross products, triple products and the hit tests,
// 20 stages of the divider pipeline each resolve one quotient bit of t (and
// of u and v in the first 17), and 2 stages check the limit and form the hit
// point. A new word is accepted every cycle while m_axis is not stalled.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stall on m_axis fills the bubbles first and only then
// deasserts s_axis_tready; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline then accepts words at once.
// A miss returns zeros in every field but the tags.
// ----------------------------------------------------------------------------
module ray_triangle_intersect import rti_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// ray_origin[62:0], ray_direction[125:63], vertex_a[188:126],
	// vertex_b[251:189], vertex_c[314:252], ray_limit[334:315],
	// triangle_index[350:335], sample_index[366:351], zero pad[367]
	input  logic [367:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// bary_u[16:0], bary_v[33:17], ray_param[53:34], hit_point[116:54],
	// triangle_tag[132:117], sample_tag[148:133], zero pad[151:149]
	output logic [151:0] m_axis_tdata,
	// hit[0]
	output logic         m_axis_tuser
);

	localparam int NF = 8;
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};
	localparam logic signed [SUMW-1:0] SMAX = SUMW'((1 << (CW - 1)) - 1);
	localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

	// Front pipeline handshake.
	logic [NF:1]   vf;
	logic [NF+1:1] rf;
	logic          div_in_ready;

	assign rf[NF+1] = div_in_ready;
	for (genvar g = 1; g <= NF; g++) begin : g_rdy
		assign rf[g] = !vf[g] || rf[g+1];
	end
	assign s_axis_tready = rf[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf <= '0;
		end else begin
			if (rf[1]) begin
				vf[1] <= s_axis_tvalid;
			end
			for (int i = 2; i <= NF; i++) begin
				if (rf[i]) begin
					vf[i] <= vf[i-1];
				end
			end
		end
	end

	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;

	// Stage 1: unpack, edges e1 = b - a, e2 = c - a, negated direction, o - a.
	evec_t e1_s1, e2_s1, kv_s1, bb_s1;

	always_ff @(posedge clk) begin
		if (rf[1]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(coord(s_axis_tdata[251:189], i))
				          - EW'(coord(s_axis_tdata[188:126], i));
				e2_s1[i] <= EW'(coord(s_axis_tdata[314:252], i))
				          - EW'(coord(s_axis_tdata[188:126], i));
				kv_s1[i] <= -EW'(coord(s_axis_tdata[125:63], i));
				bb_s1[i] <= EW'(coord(s_axis_tdata[62:0], i))
				          - EW'(coord(s_axis_tdata[188:126], i));
			end
			side_s1.org     <= s_axis_tdata[62:0];
			side_s1.dir     <= s_axis_tdata[125:63];
			side_s1.lim     <= s_axis_tdata[334:315];
			side_s1.tri_tag <= s_axis_tdata[350:335];
			side_s1.smp_tag <= s_axis_tdata[366:351];
			side_s1.hit     <= 1'b0;
		end
	end

	// Stage 2: products of the three cross products e2 x k, k x e1, e1 x e2.
	logic signed [PW-1:0] pa_s2 [3][3];
	logic signed [PW-1:0] pb_s2 [3][3];
	evec_t e1_s2, bb_s2;

	always_ff @(posedge clk) begin
		if (rf[2]) begin
			for (int i = 0; i < 3; i++) begin
				pa_s2[0][i] <= PW'(e2_s1[NXT[i]]) * PW'(kv_s1[PRV[i]]);
				pb_s2[0][i] <= PW'(e2_s1[PRV[i]]) * PW'(kv_s1[NXT[i]]);
				pa_s2[1][i] <= PW'(kv_s1[NXT[i]]) * PW'(e1_s1[PRV[i]]);
				pb_s2[1][i] <= PW'(kv_s1[PRV[i]]) * PW'(e1_s1[NXT[i]]);
				pa_s2[2][i] <= PW'(e1_s1[NXT[i]]) * PW'(e2_s1[PRV[i]]);
				pb_s2[2][i] <= PW'(e1_s1[PRV[i]]) * PW'(e2_s1[NXT[i]]);
			end
			e1_s2   <= e1_s1;
			bb_s2   <= bb_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: cross product components.
	logic signed [XW-1:0] cr_s3 [3][3];
	evec_t e1_s3, bb_s3;

	always_ff @(posedge clk) begin
		if (rf[3]) begin
			for (int c = 0; c < 3; c++) begin
				for (int i = 0; i < 3; i++) begin
					cr_s3[c][i] <= XW'(pa_s2[c][i]) - XW'(pb_s2[c][i]);
				end
			end
			e1_s3   <= e1_s2;
			bb_s3   <= bb_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: partial products of the four triple products
	// det = e1.c1, du = bb.c1, dv = bb.c2, dt = bb.c3, each cross component
	// split into a signed high and an unsigned low slice.
	logic signed [EW+XL:0]   plo_s4 [4][3];
	logic signed [EW+XH-1:0] phi_s4 [4][3];
	evec_t                   lv;
	logic signed [XW-1:0]    xv [4][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xv[0][i] = cr_s3[0][i];
			xv[1][i] = cr_s3[0][i];
			xv[2][i] = cr_s3[1][i];
			xv[3][i] = cr_s3[2][i];
			lv[i]    = e1_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (rf[4]) begin
			for (int q = 0; q < 4; q++) begin
				for (int i = 0; i < 3; i++) begin
					plo_s4[q][i] <= (EW+XL+1)'(q == 0 ? lv[i] : bb_s3[i])
					              * signed'({1'b0, xv[q][i][XL-1:0]});
					phi_s4[q][i] <= (EW+XH)'(q == 0 ? lv[i] : bb_s3[i])
					              * (EW+XH)'(signed'(xv[q][i][XW-1:XL]));
				end
			end
			side_s4 <= side_s3;
		end
	end

	// Stage 5: recombine the slices.
	logic signed [DW-1:0] pf_s5 [4][3];

	always_ff @(posedge clk) begin
		if (rf[5]) begin
			for (int q = 0; q < 4; q++) begin
				for (int i = 0; i < 3; i++) begin
					pf_s5[q][i] <= (DW'(phi_s4[q][i]) <<< XL) + DW'(plo_s4[q][i]);
				end
			end
			side_s5 <= side_s4;
		end
	end

	// Stage 6: sum the three terms of each determinant.
	logic signed [SW-1:0] dd_s6 [4];

	always_ff @(posedge clk) begin
		if (rf[6]) begin
			for (int q = 0; q < 4; q++) begin
				dd_s6[q] <= SW'(pf_s5[q][0]) + SW'(pf_s5[q][1]) + SW'(pf_s5[q][2]);
			end
			side_s6 <= side_s5;
		end
	end

	// Stage 7: negate all four determinants when the main one is negative.
	logic signed [SW-1:0] dd_s7 [4];
	logic                 nz_s7;

	always_ff @(posedge clk) begin
		if (rf[7]) begin
			for (int q = 0; q < 4; q++) begin
				dd_s7[q] <= dd_s6[0][SW-1] ? -dd_s6[q] : dd_s6[q];
			end
			nz_s7   <= dd_s6[0] != '0;
			side_s7 <= side_s6;
		end
	end

	// Stage 8: exact hit tests on the determinants, including t below 1024.
	logic hit7;
	div_t dv_s8;

	always_comb begin
		hit7 = nz_s7
		    && !dd_s7[1][SW-1] && (dd_s7[1] <= dd_s7[0])
		    && !dd_s7[2][SW-1] && (dd_s7[2] <= dd_s7[0])
		    && ((SW+1)'(dd_s7[1]) + (SW+1)'(dd_s7[2]) <= (SW+1)'(dd_s7[0]))
		    && !dd_s7[3][SW-1] && (dd_s7[3] != '0)
		    && ((SW+TFRAC)'(dd_s7[3]) < ((SW+TFRAC)'(dd_s7[0]) <<< TFRAC));
	end

	always_ff @(posedge clk) begin
		if (rf[8]) begin
			dv_s8.rt  <= TRW'($unsigned(dd_s7[3]));
			dv_s8.ru  <= URW'($unsigned(dd_s7[1]));
			dv_s8.rv  <= URW'($unsigned(dd_s7[2]));
			dv_s8.den <= $unsigned(dd_s7[0]);
			dv_s8.qt  <= '0;
			dv_s8.qu  <= '0;
			dv_s8.qv  <= '0;
			side_s8.org     <= side_s7.org;
			side_s8.dir     <= side_s7.dir;
			side_s8.lim     <= side_s7.lim;
			side_s8.tri_tag <= side_s7.tri_tag;
			side_s8.smp_tag <= side_s7.smp_tag;
			side_s8.hit     <= hit7;
		end
	end

	// Divider pipeline.
	logic  div_out_valid;
	logic  div_out_ready;
	div_t  div_q;
	side_t div_side;

	rti_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vf[NF]),
		.in_ready  (div_in_ready),
		.in_data   (dv_s8),
		.in_side   (side_s8),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.out_data  (div_q),
		.out_side  (div_side)
	);

	// Back end: limit test and t times direction, then the hit point.
	logic [2:1] vb;
	logic [3:1] rb;

	assign rb[3] = m_axis_tready;
	assign rb[2] = !vb[2] || rb[3];
	assign rb[1] = !vb[1] || rb[2];
	assign div_out_ready = rb[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb <= '0;
		end else begin
			if (rb[1]) begin
				vb[1] <= div_out_valid;
			end
			if (rb[2]) begin
				vb[2] <= vb[1];
			end
		end
	end

	logic signed [PRW-1:0] pr_s9 [3];
	logic [TQW-1:0]        qt_s9;
	logic [UQW-1:0]        qu_s9;
	logic [UQW-1:0]        qv_s9;
	logic [PKW-1:0]        org_s9;
	logic [TAGW-1:0]       ttag_s9;
	logic [TAGW-1:0]       stag_s9;
	logic                  hit_s9;

	always_ff @(posedge clk) begin
		if (rb[1]) begin
			for (int i = 0; i < 3; i++) begin
				pr_s9[i] <= PRW'(signed'({1'b0, div_q.qt})) * PRW'(coord(div_side.dir, i));
			end
			qt_s9   <= div_q.qt;
			qu_s9   <= div_q.qu;
			qv_s9   <= div_q.qv;
			org_s9  <= div_side.org;
			ttag_s9 <= div_side.tri_tag;
			stag_s9 <= div_side.smp_tag;
			hit_s9  <= div_side.hit && (div_q.qt < div_side.lim);
		end
	end

	logic signed [SUMW-1:0] hs   [3];
	logic [PKW-1:0]         hp;

	always_comb begin
		hp = '0;
		for (int i = 0; i < 3; i++) begin
			hs[i] = SUMW'(coord(org_s9, i)) + SUMW'(pr_s9[i] >>> TFRAC);
			if (hs[i] > SMAX) begin
				hs[i] = SMAX;
			end else if (hs[i] < SMIN) begin
				hs[i] = SMIN;
			end
			hp[i*CW +: CW] = hs[i][CW-1:0];
		end
	end

	logic [151:0] data_s10;
	logic         hit_s10;

	always_ff @(posedge clk) begin
		if (rb[2]) begin
			data_s10[16:0]    <= hit_s9 ? qu_s9 : '0;
			data_s10[33:17]   <= hit_s9 ? qv_s9 : '0;
			data_s10[53:34]   <= hit_s9 ? qt_s9 : '0;
			data_s10[116:54]  <= hit_s9 ? hp : '0;
			data_s10[132:117] <= ttag_s9;
			data_s10[148:133] <= stag_s9;
			data_s10[151:149] <= '0;
			hit_s10           <= hit_s9;
		end
	end

	assign m_axis_tvalid = vb[2];
	assign m_axis_tdata  = data_s10;
	assign m_axis_tuser  = hit_s10;

endmodule

FILE: rtl/rti_checker.sv
// ----------------------------------------------------------------------------
// rti_checker: port-level checks of the ray/triangle intersector
// Watches the output channel for stall behavior and result consistency.
// ----------------------------------------------------------------------------
module rti_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [151:0] m_axis_tdata,
	input logic         m_axis_tuser
);

	// A stalled word stays and holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// A miss carries zeros in every field but the tags.
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[116:0] == '0)
		else $error("miss with nonzero payload");

	// On a hit the weights stay inside the triangle.
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		({1'b0, m_axis_tdata[16:0]} + {1'b0, m_axis_tdata[33:17]}) <= 18'd65536)
		else $error("u + v above one");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[151:149] == '0)
		else $error("pad bits set");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
